/* rtl/ttsd_pkg.sv */
// Shared types and constants for the touch tap and slide detector.
package ttsd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MIN_HOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL_LIMIT  = 3'd4;

  localparam int NEAR_W    = 9;
  localparam int RELEASE_W = 8;
  localparam int LIMIT_W   = 16;

  localparam logic [NEAR_W-1:0]    NEAR_X_RST        = 9'd20;
  localparam logic [NEAR_W-1:0]    NEAR_Y_RST        = 9'd20;
  localparam logic [RELEASE_W-1:0] RELEASE_LIMIT_RST = 8'd3;
  localparam logic [LIMIT_W-1:0]   TAP_MIN_HOLD_RST  = 16'd2;
  localparam logic [LIMIT_W-1:0]   CANCEL_LIMIT_RST  = 16'd5;

  // n/5 == (n * 52429) >> 18, exact for n below 2**18
  localparam int              DIV5_MUL_W = 16;
  localparam logic [15:0]     DIV5_MUL   = 16'd52429;
  localparam int              DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TOUCH = 2'd1,
    PH_SLIDE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    DIR_EAST   = 3'd0,
    DIR_WEST   = 3'd1,
    DIR_NORTH  = 3'd2,
    DIR_SOUTH  = 3'd3,
    DIR_NONE   = 3'd4,
    DIR_CANCEL = 3'd5,
    DIR_NEAR   = 3'd6
  } dir_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_TAP   = 2'd1,
    EV_SLIDE = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [NEAR_W-1:0]    near_x_limit;
    logic [NEAR_W-1:0]    near_y_limit;
    logic [RELEASE_W-1:0] release_limit;
    logic [LIMIT_W-1:0]   tap_min_hold;
    logic [LIMIT_W-1:0]   cancel_limit;
  } cfg_t;

endpackage

/* rtl/ttsd_if.sv */
// Valid/ready channel interfaces for touch samples and detected events.
interface ttsd_sample_if #(parameter int COORD_WIDTH = 9);
  logic                   valid;
  logic                   ready;
  logic                   pressed;
  logic [COORD_WIDTH-1:0] pos_x;
  logic [COORD_WIDTH-1:0] pos_y;

  modport source (output valid, output pressed, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pressed, input pos_x, input pos_y, output ready);
endinterface

interface ttsd_event_if #(parameter int COORD_WIDTH = 9);
  logic                   valid;
  logic                   ready;
  logic [1:0]             event_kind;
  logic [COORD_WIDTH-1:0] tap_x;
  logic [COORD_WIDTH-1:0] tap_y;
  logic [1:0]             swipe_dir;

  modport source (output valid, output event_kind, output tap_x, output tap_y,
                  output swipe_dir, input ready);
  modport sink   (input valid, input event_kind, input tap_x, input tap_y,
                  input swipe_dir, output ready);
endinterface

/* rtl/ttsd_core.sv */
// Gesture state registers and the per-sample classify and update logic.
module ttsd_core #(
  parameter int COORD_WIDTH = 9,
  parameter int HOLD_WIDTH  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  ttsd_pkg::cfg_t          cfg_i,
  input  logic                    pressed_i,
  input  logic [COORD_WIDTH-1:0]  pos_x_i,
  input  logic [COORD_WIDTH-1:0]  pos_y_i,
  output ttsd_pkg::event_kind_e   event_kind_o,
  output logic [COORD_WIDTH-1:0]  tap_x_o,
  output logic [COORD_WIDTH-1:0]  tap_y_o,
  output logic [1:0]              swipe_dir_o
);
  import ttsd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NCW = (CW > NEAR_W) ? CW : NEAR_W;
  localparam int HCW = (HOLD_WIDTH > LIMIT_W) ? HOLD_WIDTH : LIMIT_W;
  localparam int SW  = CW + 3;
  localparam int PW  = SW + DIV5_MUL_W;

  phase_e                 phase_q, phase_d;
  dir_e                   dir_q, dir_d;
  logic [HOLD_WIDTH-1:0]  hold_q, hold_d;
  logic [RELEASE_W-1:0]   rel_q, rel_d;
  logic [CW-1:0]          anc_x_q, anc_x_d;
  logic [CW-1:0]          anc_y_q, anc_y_d;

  logic signed [CW:0]     dx, dy;
  logic [CW-1:0]          adx, ady;
  logic [CW:0]            ady2;
  logic                   near;
  dir_e                   cls;
  logic [HOLD_WIDTH-1:0]  hold_inc;
  logic [RELEASE_W-1:0]   rel_inc;
  logic [SW-1:0]          sum_x, sum_y;
  logic [PW-1:0]          prod_x, prod_y;
  logic [CW-1:0]          smooth_x, smooth_y;

  // Direction relative to the anchor; vertical distance counts double
  always_comb begin
    dx   = $signed({1'b0, pos_x_i}) - $signed({1'b0, anc_x_q});
    dy   = $signed({1'b0, pos_y_i}) - $signed({1'b0, anc_y_q});
    adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    ady2 = {ady, 1'b0};
    near = (NCW'(adx) < NCW'(cfg_i.near_x_limit)) &&
           (NCW'(ady) < NCW'(cfg_i.near_y_limit));
    if (near) begin
      cls = DIR_NEAR;
    end else if ((CW + 1)'(adx) > ady2) begin
      cls = (!dx[CW] && (dx != '0)) ? DIR_EAST : DIR_WEST;
    end else begin
      cls = (!dy[CW] && (dy != '0)) ? DIR_NORTH : DIR_SOUTH;
    end
  end

  // Anchor smoothing (4*old + new) / 5 by reciprocal multiply
  always_comb begin
    sum_x    = SW'({anc_x_q, 2'b00}) + SW'(pos_x_i);
    sum_y    = SW'({anc_y_q, 2'b00}) + SW'(pos_y_i);
    prod_x   = PW'(sum_x) * PW'(DIV5_MUL);
    prod_y   = PW'(sum_y) * PW'(DIV5_MUL);
    smooth_x = prod_x[DIV5_SHIFT +: CW];
    smooth_y = prod_y[DIV5_SHIFT +: CW];
  end

  assign hold_inc = (&hold_q) ? hold_q : hold_q + 1'b1;
  assign rel_inc  = (&rel_q) ? rel_q : rel_q + 1'b1;

  always_comb begin
    phase_d      = phase_q;
    dir_d        = dir_q;
    hold_d       = hold_q;
    rel_d        = rel_q;
    anc_x_d      = anc_x_q;
    anc_y_d      = anc_y_q;
    event_kind_o = EV_NONE;
    tap_x_o      = '0;
    tap_y_o      = '0;
    swipe_dir_o  = '0;
    case (phase_q)
      PH_TOUCH: begin
        if (!pressed_i) begin
          if (rel_q > cfg_i.release_limit) begin
            if (HCW'(hold_q) >= HCW'(cfg_i.tap_min_hold)) begin
              event_kind_o = EV_TAP;
              tap_x_o      = anc_x_q;
              tap_y_o      = anc_y_q;
            end
            phase_d = PH_IDLE;
          end
          rel_d = rel_inc;
        end else begin
          if (cls == DIR_NEAR) begin
            anc_x_d = smooth_x;
            anc_y_d = smooth_y;
            hold_d  = hold_inc;
          end else begin
            dir_d   = cls;
            anc_x_d = pos_x_i;
            anc_y_d = pos_y_i;
            hold_d  = '0;
            phase_d = PH_SLIDE;
          end
          rel_d = rel_q >> 1;
        end
      end
      PH_SLIDE: begin
        if (!pressed_i) begin
          if (rel_q >= cfg_i.release_limit) begin
            if (dir_q != DIR_CANCEL) begin
              event_kind_o = EV_SLIDE;
              swipe_dir_o  = dir_q[1:0];
            end
            phase_d = PH_IDLE;
          end
          rel_d = rel_inc;
        end else if (cls != DIR_NEAR && cls != dir_q) begin
          hold_d = hold_inc;
          if (HCW'(hold_inc) > HCW'(cfg_i.cancel_limit)) begin
            dir_d = DIR_CANCEL;
          end
        end else if (cls != DIR_NEAR) begin
          anc_x_d = pos_x_i;
          anc_y_d = pos_y_i;
          rel_d   = rel_q >> 1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (pressed_i) begin
          phase_d = PH_TOUCH;
          dir_d   = DIR_NONE;
          hold_d  = HOLD_WIDTH'(1);
          rel_d   = '0;
          anc_x_d = pos_x_i;
          anc_y_d = pos_y_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dir_q   <= DIR_NONE;
      hold_q  <= '0;
      rel_q   <= '0;
      anc_x_q <= '1;
      anc_y_q <= '1;
    end else if (step_i) begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      hold_q  <= hold_d;
      rel_q   <= rel_d;
      anc_x_q <= anc_x_d;
      anc_y_q <= anc_y_d;
    end
  end

endmodule

/* rtl/touch_tap_slide_detector.sv */
// Top level of the touch tap and slide detector.
// Takes one touch sample per clock while the output is not stalled and returns
// exactly one event item per sample (nothing, a tap with its smoothed position,
// or a slide with its direction). A sample is latched in an input register,
// runs through the classifier and the divide-by-five anchor smoothing against
// the gesture state, and its event lands in the output register. One item per
// cycle is sustained while the output is not stalled because the state feedback
// loop closes combinationally through the classifier and smoothing. A stalled
// result holds the output register; the input register takes one more sample
// only if it is empty, after which input stalls until the output side drains.
// Threshold registers are written by index over the cfg port; the user must
// write them only while no sample is in flight, the block does not enforce
// this. Indexes above four are ignored.
module touch_tap_slide_detector #(
  parameter int COORD_WIDTH = 9,
  parameter int HOLD_WIDTH  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ttsd_sample_if.sink                        sample_i,
  ttsd_event_if.source                       event_o,
  input  logic                               cfg_we_i,
  input  logic [ttsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ttsd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ttsd_pkg::*;

  cfg_t                   cfg_q;

  logic                   in_valid_q;
  logic                   in_pressed_q;
  logic [COORD_WIDTH-1:0] in_x_q, in_y_q;
  logic                   in_ready;
  logic                   advance;
  logic                   step;

  logic                   out_valid_q;
  event_kind_e            kind_d;
  logic [1:0]             kind_q;
  logic [COORD_WIDTH-1:0] tap_x_d, tap_y_d, tap_x_q, tap_y_q;
  logic [1:0]             dir_d, dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_x_limit  <= NEAR_X_RST;
      cfg_q.near_y_limit  <= NEAR_Y_RST;
      cfg_q.release_limit <= RELEASE_LIMIT_RST;
      cfg_q.tap_min_hold  <= TAP_MIN_HOLD_RST;
      cfg_q.cancel_limit  <= CANCEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEAR_X:        cfg_q.near_x_limit  <= cfg_data_i[NEAR_W-1:0];
        REG_NEAR_Y:        cfg_q.near_y_limit  <= cfg_data_i[NEAR_W-1:0];
        REG_RELEASE_LIMIT: cfg_q.release_limit <= cfg_data_i[RELEASE_W-1:0];
        REG_TAP_MIN_HOLD:  cfg_q.tap_min_hold  <= cfg_data_i[LIMIT_W-1:0];
        REG_CANCEL_LIMIT:  cfg_q.cancel_limit  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance        = !out_valid_q || event_o.ready;
  assign in_ready       = !in_valid_q || advance;
  assign step           = in_valid_q && advance;
  assign sample_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && sample_i.valid) begin
      in_pressed_q <= sample_i.pressed;
      in_x_q       <= sample_i.pos_x;
      in_y_q       <= sample_i.pos_y;
    end
  end

  ttsd_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .HOLD_WIDTH  (HOLD_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cfg_i        (cfg_q),
    .pressed_i    (in_pressed_q),
    .pos_x_i      (in_x_q),
    .pos_y_i      (in_y_q),
    .event_kind_o (kind_d),
    .tap_x_o      (tap_x_d),
    .tap_y_o      (tap_y_d),
    .swipe_dir_o  (dir_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      kind_q  <= kind_d;
      tap_x_q <= tap_x_d;
      tap_y_q <= tap_y_d;
      dir_q   <= dir_d;
    end
  end

  assign event_o.valid      = out_valid_q;
  assign event_o.event_kind = kind_q;
  assign event_o.tap_x      = tap_x_q;
  assign event_o.tap_y      = tap_y_q;
  assign event_o.swipe_dir  = dir_q;

endmodule

/* rtl/ttsd_checker.sv */
// Port-level assertions for the touch tap and slide detector, bound to the top.
module ttsd_checker #(
  parameter int COORD_WIDTH = 9
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [1:0]             event_kind_i,
  input logic [COORD_WIDTH-1:0] tap_x_i,
  input logic [COORD_WIDTH-1:0] tap_y_i,
  input logic [1:0]             swipe_dir_i
);
  import ttsd_pkg::*;

  // A stalled event item keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
      $stable(tap_x_i) && $stable(tap_y_i) && $stable(swipe_dir_i))
    else $error("event item changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_kind_i == EV_NONE || event_kind_i == EV_TAP ||
      event_kind_i == EV_SLIDE)
    else $error("unknown event kind");

  // Position is only carried by taps
  a_tap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i != EV_TAP |-> tap_x_i == '0 && tap_y_i == '0)
    else $error("tap position on a non-tap event");

  a_swipe_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i != EV_SLIDE |-> swipe_dir_i == '0)
    else $error("slide direction on a non-slide event");

endmodule

bind touch_tap_slide_detector ttsd_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ttsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (event_o.valid),
  .out_ready_i  (event_o.ready),
  .event_kind_i (event_o.event_kind),
  .tap_x_i      (event_o.tap_x),
  .tap_y_i      (event_o.tap_y),
  .swipe_dir_i  (event_o.swipe_dir)
);

/* test/touch_tap_slide_detector_checker.sv */
// Checker for the touch tap and slide detector: predicts each event item and compares.
`timescale 1ns / 1ps
module touch_tap_slide_detector_checker #(
  parameter int CW = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ttsd_sample_if                          smp,
  ttsd_event_if                           evt,
  input  logic                            cfg_we_i,
  input  logic [ttsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ttsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);
  import ttsd_pkg::*;

  localparam int              HOLD_W   = 16;
  localparam logic [HOLD_W-1:0] HOLD_SAT = '1;
  localparam logic [7:0]      REL_SAT  = 8'hFF;

  typedef struct packed {
    event_kind_e   kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [1:0]    dir;
  } touch_event_t;

  cfg_t           lim;
  phase_e         ph;
  dir_e           heading;
  logic [HOLD_W-1:0] hold_cnt;
  logic [7:0]     rel_cnt;
  logic [CW-1:0]  anc_x;
  logic [CW-1:0]  anc_y;

  touch_event_t   event_q[$];
  touch_event_t   want;
  int             n_fail;

  // vertical distance counts double
  function automatic dir_e move_dir(logic [CW-1:0] x, logic [CW-1:0] y);
    int dx, dy, adx, ady2;
    dx   = int'(x) - int'(anc_x);
    dy   = int'(y) - int'(anc_y);
    adx  = (dx < 0) ? -dx : dx;
    ady2 = 2 * ((dy < 0) ? -dy : dy);
    if (adx < int'(lim.near_x_limit) && ady2 < 2 * int'(lim.near_y_limit)) return DIR_NEAR;
    if (adx > ady2) return (dx > 0) ? DIR_EAST : DIR_WEST;
    return (dy > 0) ? DIR_NORTH : DIR_SOUTH;
  endfunction

  function automatic touch_event_t predict_event(logic p, logic [CW-1:0] x, logic [CW-1:0] y);
    touch_event_t ev;
    dir_e         d;
    int           sx, sy;
    ev      = '0;
    ev.kind = EV_NONE;
    case (ph)
      PH_TOUCH: begin
        if (!p) begin
          if (rel_cnt > lim.release_limit) begin
            if (hold_cnt >= lim.tap_min_hold) begin
              ev.kind = EV_TAP;
              ev.x    = anc_x;
              ev.y    = anc_y;
            end
            ph = PH_IDLE;
          end
          if (rel_cnt != REL_SAT) rel_cnt++;
        end else begin
          d = move_dir(x, y);
          if (d == DIR_NEAR) begin
            sx    = (int'(anc_x) * 4 + int'(x)) / 5;
            sy    = (int'(anc_y) * 4 + int'(y)) / 5;
            anc_x = sx[CW-1:0];
            anc_y = sy[CW-1:0];
            if (hold_cnt != HOLD_SAT) hold_cnt++;
          end else begin
            heading  = d;
            anc_x    = x;
            anc_y    = y;
            hold_cnt = '0;
            ph       = PH_SLIDE;
          end
          rel_cnt = rel_cnt >> 1;
        end
      end
      PH_SLIDE: begin
        if (!p) begin
          if (rel_cnt >= lim.release_limit) begin
            if (heading != DIR_CANCEL) begin
              ev.kind = EV_SLIDE;
              ev.dir  = heading[1:0];
            end
            ph = PH_IDLE;
          end
          if (rel_cnt != REL_SAT) rel_cnt++;
        end else begin
          d = move_dir(x, y);
          if (d != DIR_NEAR && d != heading) begin
            if (hold_cnt != HOLD_SAT) hold_cnt++;
            if (hold_cnt > lim.cancel_limit) heading = DIR_CANCEL;
          end else if (d != DIR_NEAR) begin
            anc_x   = x;
            anc_y   = y;
            rel_cnt = rel_cnt >> 1;
          end
        end
      end
      default: begin
        ph = PH_IDLE;
        if (p) begin
          ph       = PH_TOUCH;
          heading  = DIR_NONE;
          hold_cnt = 1;
          rel_cnt  = '0;
          anc_x    = x;
          anc_y    = y;
        end
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim.near_x_limit  = NEAR_X_RST;
      lim.near_y_limit  = NEAR_Y_RST;
      lim.release_limit = RELEASE_LIMIT_RST;
      lim.tap_min_hold  = TAP_MIN_HOLD_RST;
      lim.cancel_limit  = CANCEL_LIMIT_RST;
      ph         = PH_IDLE;
      heading    = DIR_NONE;
      hold_cnt   = '0;
      rel_cnt    = '0;
      anc_x      = '1;
      anc_y      = '1;
      n_fail     = 0;
      event_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NEAR_X:        lim.near_x_limit  = cfg_data_i[NEAR_W-1:0];
          REG_NEAR_Y:        lim.near_y_limit  = cfg_data_i[NEAR_W-1:0];
          REG_RELEASE_LIMIT: lim.release_limit = cfg_data_i[RELEASE_W-1:0];
          REG_TAP_MIN_HOLD:  lim.tap_min_hold  = cfg_data_i[LIMIT_W-1:0];
          REG_CANCEL_LIMIT:  lim.cancel_limit  = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        event_q.push_back(predict_event(smp.pressed, smp.pos_x, smp.pos_y));
      end
      if (evt.valid && evt.ready) begin
        if (event_q.size() == 0) begin
          if (n_fail < 10) $display("%0t: event item with none pending: kind %0d", $time,
                                    evt.event_kind);
          n_fail++;
        end else begin
          want = event_q.pop_front();
          if (evt.event_kind !== want.kind || evt.tap_x !== want.x ||
              evt.tap_y !== want.y || evt.swipe_dir !== want.dir) begin
            if (n_fail < 10) begin
              $display("%0t: event mismatch: exp kind %0d tap %0d,%0d dir %0d", $time,
                       want.kind, want.x, want.y, want.dir);
              $display("%0t:                 got kind %0d tap %0d,%0d dir %0d", $time,
                       evt.event_kind, evt.tap_x, evt.tap_y, evt.swipe_dir);
            end
            n_fail++;
          end
        end
      end
      fail_cnt_o <= n_fail;
      pending_o  <= event_q.size();
    end
  end

endmodule

/* test/touch_tap_slide_detector_test.sv */
// Testbench top for the touch tap and slide detector: touch stimulus, config phases, verdict.
`timescale 1ns / 1ps
module touch_tap_slide_detector_test;
  import ttsd_pkg::*;

  localparam int CW      = 9;
  localparam int MAX_POS = 511;
  // no register lives here, the block must ignore the write
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_cnt;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_in_phase;
  int lim_near_x;
  int lim_near_y;
  int lim_release;

  ttsd_sample_if #(.COORD_WIDTH(CW)) sample_ch ();
  ttsd_event_if  #(.COORD_WIDTH(CW)) event_ch ();

  touch_tap_slide_detector #(
    .COORD_WIDTH(CW),
    .HOLD_WIDTH (16)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_ch),
    .event_o   (event_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  touch_tap_slide_detector_checker #(.CW(CW)) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp       (sample_ch),
    .evt       (event_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      event_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic int clip(int v);
    return (v < 0) ? 0 : ((v > MAX_POS) ? MAX_POS : v);
  endfunction

  task automatic put_sample(input logic p, input int x, input int y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.pressed <= p;
    sample_ch.pos_x   <= CW'(x);
    sample_ch.pos_y   <= CW'(y);
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    sent_in_phase++;
  endtask

  // wait until every event item is back, plus a margin
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input int nx, input int ny, input int rel, input int tap_min,
                              input int cancel);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NEAR_X;
    cfg_data_i <= CFG_DATA_W'(nx);
    @(posedge clk_i);
    cfg_idx_i  <= REG_NEAR_Y;
    cfg_data_i <= CFG_DATA_W'(ny);
    @(posedge clk_i);
    cfg_idx_i  <= REG_RELEASE_LIMIT;
    cfg_data_i <= CFG_DATA_W'(rel);
    @(posedge clk_i);
    cfg_idx_i  <= REG_TAP_MIN_HOLD;
    cfg_data_i <= CFG_DATA_W'(tap_min);
    @(posedge clk_i);
    cfg_idx_i  <= REG_CANCEL_LIMIT;
    cfg_data_i <= CFG_DATA_W'(cancel);
    @(posedge clk_i);
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_near_x  = nx;
    lim_near_y  = ny;
    lim_release = rel;
  endtask

  // one press-to-release gesture: a hold, a slide, or noise
  task automatic play_gesture();
    int   ax, ay, pick, n, step, jx, jy;
    dir_e way;
    ax   = $urandom_range(0, MAX_POS);
    ay   = $urandom_range(0, MAX_POS);
    pick = $urandom_range(0, 9);
    put_sample(1'b1, ax, ay);
    if (pick < 4) begin
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 7) == 0) begin
          put_sample(1'b0, $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
        end else begin
          jx = $urandom_range(0, lim_near_x / 2);
          jy = $urandom_range(0, lim_near_y / 2);
          if ($urandom_range(0, 1)) jx = -jx;
          if ($urandom_range(0, 1)) jy = -jy;
          put_sample(1'b1, clip(ax + jx), clip(ay + jy));
        end
      end
    end else if (pick < 8) begin
      way = dir_e'($urandom_range(0, 3));
      repeat ($urandom_range(1, 8)) begin
        n = $urandom_range(0, 9);
        // a turn can make later moves off-direction
        if (n == 0) way = dir_e'($urandom_range(0, 3));
        if (n == 1) begin
          put_sample(1'b0, $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
        end else begin
          step = ((way == DIR_EAST || way == DIR_WEST) ? lim_near_x : lim_near_y) +
                 $urandom_range(1, 80);
          case (way)
            DIR_EAST:  ax = clip(ax + step);
            DIR_WEST:  ax = clip(ax - step);
            DIR_NORTH: ay = clip(ay + step);
            default:   ay = clip(ay - step);
          endcase
          put_sample(1'b1, ax, ay);
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        put_sample($urandom_range(0, 1), $urandom_range(0, MAX_POS),
                   $urandom_range(0, MAX_POS));
      end
    end
    // mostly a release long enough to end the gesture
    if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 3);
    else n = lim_release + $urandom_range(1, 3);
    repeat (n) put_sample(1'b0, $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
  endtask

  task automatic run_phase(input int budget, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent_in_phase  = 0;
    while (sent_in_phase < budget) play_gesture();
    settle();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.pressed <= 1'b0;
    sample_ch.pos_x   <= '0;
    sample_ch.pos_y   <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_in_phase  = 0;
    lim_near_x     = int'(NEAR_X_RST);
    lim_near_y     = int'(NEAR_Y_RST);
    lim_release    = int'(RELEASE_LIMIT_RST);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset thresholds
    put_sample(1'b0, MAX_POS, 0);
    put_sample(1'b1, 0, 0);
    put_sample(1'b1, 3, 2);
    put_sample(1'b1, 1, 1);
    repeat (5) put_sample(1'b0, 0, MAX_POS);
    // south slide from the far corner with a westward stray
    put_sample(1'b1, MAX_POS, MAX_POS);
    put_sample(1'b1, MAX_POS, 400);
    put_sample(1'b1, 0, 400);
    repeat (4) put_sample(1'b0, MAX_POS, 0);
    // east slide with a northward stray
    put_sample(1'b1, 0, 0);
    put_sample(1'b1, 100, 0);
    put_sample(1'b1, 100, 300);
    repeat (4) put_sample(1'b0, 0, 0);
    settle();

    write_limits(0, 0, 0, 0, 0);
    run_phase(230, 75, 0);
    write_limits(MAX_POS, MAX_POS, 1, 65535, 65535);
    run_phase(230, 0, 75);
    write_limits(20, 20, 3, 2, 5);
    run_phase(290, 29, 29);
    write_limits(12, 40, 250, 1, 0);
    run_phase(290, 0, 0);
    // release count saturates, a touch can no longer end
    write_limits(40, 10, 255, 3, 2);
    run_phase(70, 29, 29);
    write_limits(30, 25, 2, 4, 3);
    run_phase(170, 0, 0);

    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/ttsd_pkg.sv
rtl/ttsd_if.sv
rtl/ttsd_core.sv
rtl/touch_tap_slide_detector.sv
rtl/ttsd_checker.sv
test/touch_tap_slide_detector_checker.sv
test/touch_tap_slide_detector_test.sv
